@@ rtl/core/sae_pkg.sv @@
// Shared types and codes of the stack allocator engine.
package sae_pkg;

  typedef enum logic [1:0] {
    ACT_ALLOC    = 2'd0,
    ACT_FREE     = 2'd1,
    ACT_RESIZE   = 2'd2,
    ACT_FREE_ALL = 2'd3
  } action_e;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_OOM     = 3'd1;
  localparam logic [2:0] ST_BOUNDS  = 3'd2;
  localparam logic [2:0] ST_ORDER   = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  localparam logic CFG_BUFFER_BASE = 1'b0;
  localparam logic CFG_REGION_LEN  = 1'b1;

  localparam logic [12:0] REGION_LEN_RST = 13'd4096;

  typedef struct packed {
    action_e     action;
    logic [31:0] address;
    logic [12:0] request_size;
    logic [12:0] cur_size;
    logic [2:0]  align_log2;
  } sae_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_address;
    logic [12:0] copy_bytes;
    logic [12:0] zero_bytes;
    logic [12:0] used_bytes;
  } sae_out_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } sae_cmd_t;

endpackage

@@ rtl/core/sae_ctrl.sv @@
// Sequencer of the stack allocator engine: capture, commit and output handshake.
module sae_ctrl
  import sae_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sae_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || !out_stall_i;

  assign cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.commit  = (state_q == S_EXEC) && slot_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.capture) state_d = S_EXEC;
      end
      S_EXEC: begin
        // hold until the output register can take the beat
        if (cmd_o.commit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/core/sae_datapath.sv @@
// Datapath of the stack allocator engine: offsets, header store and result register.
module sae_datapath
  import sae_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES   = 4096,
  parameter int unsigned HEADER_BYTES   = 16,
  parameter int unsigned MAX_ALIGN_LOG2 = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sae_cmd_t    cmd_i,
  input  sae_in_t     in_data_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output sae_out_t    out_data_o
);

  localparam int unsigned AMAX = 1 << MAX_ALIGN_LOG2;
  localparam int unsigned OW   = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned IW   = $clog2(BUFFER_BYTES);
  localparam int unsigned PW   = $clog2(HEADER_BYTES + AMAX);
  localparam int unsigned PCW  = PW + 1;
  localparam int unsigned SW   = $clog2(BUFFER_BYTES + HEADER_BYTES + AMAX + 8192) + 1;
  localparam int unsigned HW   = PW + OW;

  // configuration and allocator state
  logic [31:0]   base_q;
  logic [12:0]   len_q;
  logic [OW-1:0] top_q, top_d;
  logic [OW-1:0] prev_q, prev_d;

  // header store: {padding, previous top}
  logic [HW-1:0] hdr_mem [BUFFER_BYTES];
  logic [HW-1:0] hdr_rd_q;
  logic [HW-1:0] hdr_wr;
  logic [IW-1:0] hdr_wr_idx;
  logic          hdr_we;

  // capture stage
  logic [31:0]    rel_c;
  logic [3:0]     lg_sat;
  logic [PCW-1:0] cur_lo, amask, a_val, modv, pad0, need, kmul, pad_c;
  sae_in_t        in_q;
  logic [31:0]    rel_q;
  logic [PW-1:0]  pad_q;

  // commit stage
  logic [SW-1:0] eff, data_off, alloc_end;
  logic          alloc_ok, in_bounds, below_top, order_ok;
  logic [PW-1:0] hp;
  logic [OW-1:0] hv;
  logic [31:0]   nt, res_addr;
  logic          do_alloc, do_free, fill_copy;
  sae_out_t      res_c;
  sae_out_t      out_q;

  assign rel_c  = in_data_i.address - base_q;
  assign lg_sat = ({1'b0, in_data_i.align_log2} > 4'(MAX_ALIGN_LOG2)) ?
                  4'(MAX_ALIGN_LOG2) : {1'b0, in_data_i.align_log2};

  // padding from the current absolute top to the next aligned slot past the header
  always_comb begin
    cur_lo = base_q[PCW-1:0] + PCW'(top_q);
    a_val  = PCW'(1) << lg_sat;
    amask  = a_val - PCW'(1);
    modv   = cur_lo & amask;
    pad0   = (modv != '0) ? (a_val - modv) : '0;
    need   = '0;
    kmul   = '0;
    pad_c  = pad0;
    if (pad0 < PCW'(HEADER_BYTES)) begin
      need  = PCW'(HEADER_BYTES) - pad0;
      kmul  = ((need + amask) >> lg_sat) << lg_sat;
      pad_c = pad0 + kmul;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q     <= in_data_i;
      rel_q    <= rel_c;
      pad_q    <= PW'(pad_c);
      hdr_rd_q <= hdr_mem[rel_c[IW-1:0]];
    end
    if (hdr_we) begin
      hdr_mem[hdr_wr_idx] <= hdr_wr;
    end
  end

  assign hp = hdr_rd_q[HW-1:OW];
  assign hv = hdr_rd_q[OW-1:0];

  always_comb begin
    if (SW'(len_q) > SW'(BUFFER_BYTES)) eff = SW'(BUFFER_BYTES);
    else eff = SW'(len_q);
    data_off  = SW'(top_q) + SW'(pad_q);
    alloc_end = data_off + SW'(in_q.request_size);
    alloc_ok  = (alloc_end <= eff);
    res_addr  = base_q + 32'(data_off);
    in_bounds = (rel_q < 32'(eff));
    below_top = (rel_q < 32'(top_q));
    order_ok  = (32'(hp) <= rel_q) && ((rel_q - 32'(hp)) == 32'(prev_q));
    nt        = rel_q + 32'(in_q.request_size);
  end

  always_comb begin
    do_alloc  = 1'b0;
    do_free   = 1'b0;
    fill_copy = 1'b0;
    top_d     = top_q;
    prev_d    = prev_q;
    hdr_we    = 1'b0;
    hdr_wr    = {pad_q, top_q};
    hdr_wr_idx = (data_off == SW'(BUFFER_BYTES)) ? '0 : data_off[IW-1:0];
    res_c.status         = ST_OK;
    res_c.result_address = '0;
    res_c.copy_bytes     = '0;
    res_c.zero_bytes     = '0;

    case (in_q.action)
      ACT_ALLOC:    do_alloc = 1'b1;
      ACT_FREE:     do_free  = 1'b1;
      ACT_FREE_ALL: top_d    = '0;
      ACT_RESIZE: begin
        if (in_q.address == '0) begin
          do_alloc = 1'b1;
        end else if (in_q.request_size == '0) begin
          do_free = 1'b1;
        end else if (!in_bounds) begin
          res_c.status = ST_BOUNDS;
        end else if (in_q.cur_size == in_q.request_size) begin
          res_c.result_address = in_q.address;
        end else if (order_ok) begin
          // top block: grow or shrink in place
          if (nt > 32'(eff)) begin
            res_c.status = ST_OOM;
          end else begin
            top_d                = OW'(nt);
            res_c.result_address = in_q.address;
          end
        end else begin
          do_alloc  = 1'b1;
          fill_copy = 1'b1;
        end
      end
      default: top_d = top_q;
    endcase

    if (do_alloc) begin
      if (!alloc_ok) begin
        res_c.status = ST_OOM;
      end else begin
        prev_d               = top_q;
        hdr_we               = cmd_i.commit;
        top_d                = OW'(alloc_end);
        res_c.result_address = res_addr;
        res_c.zero_bytes     = in_q.request_size;
        if (fill_copy) begin
          res_c.copy_bytes = (in_q.cur_size < in_q.request_size) ?
                             in_q.cur_size : in_q.request_size;
        end
      end
    end

    if (do_free) begin
      if (in_q.address == '0) begin
        res_c.status = ST_IGNORED;
      end else if (!in_bounds) begin
        res_c.status = ST_BOUNDS;
      end else if (!below_top) begin
        res_c.status = ST_IGNORED;
      end else if (!order_ok) begin
        res_c.status = ST_ORDER;
      end else begin
        top_d  = OW'(rel_q - 32'(hp));
        prev_d = hv;
      end
    end

    res_c.used_bytes = 13'(top_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      len_q  <= REGION_LEN_RST;
      top_q  <= '0;
      prev_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BUFFER_BASE: base_q <= cfg_data_i;
          CFG_REGION_LEN:  len_q  <= cfg_data_i[12:0];
          default:         base_q <= base_q;
        endcase
      end
      if (cmd_i.commit) begin
        top_q  <= top_d;
        prev_q <= prev_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) out_q <= res_c;
  end

  assign out_data_o = out_q;

endmodule

@@ rtl/core/stack_allocator_engine.sv @@
// Top level of the stack allocator engine.
//
// LIFO region allocator over one backing buffer. Each input beat carries one
// operation (alloc, free, resize, free all) and yields exactly one result beat.
// Channels: in_valid_i/in_stall_o/in_data_i take operations, out_valid_o/
// out_stall_i/out_data_o deliver results; a beat moves when valid is high and
// stall is low. cfg_valid_i/cfg_ready_o write the buffer base (index 0) or the
// usable length (index 1); write them only while no operation is in flight.
// Timing: the accepting edge also reads the header record (registered read);
// the commit edge, once the result register is free, commits the new top offsets
// and loads the result register, from which the result beat is then valid. The
// input stays stalled until that commit, so a new operation is not taken before
// the previous one has committed.
// A result waiting under out_stall_i does not block the next operation from
// being accepted and read; its commit waits until the result register frees.
// Reset clears the top offset and the previous top, sets the buffer base to 0
// and the usable length to 4096. The header store is not cleared: a record is
// valid only once an alloc has written it.
module stack_allocator_engine
  import sae_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES   = 4096,
  parameter int unsigned HEADER_BYTES   = 16,
  parameter int unsigned MAX_ALIGN_LOG2 = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  sae_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output sae_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  sae_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  sae_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  sae_datapath #(
    .BUFFER_BYTES   (BUFFER_BYTES),
    .HEADER_BYTES   (HEADER_BYTES),
    .MAX_ALIGN_LOG2 (MAX_ALIGN_LOG2)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/core/sae_checker.sv @@
// Port-level checks of the stack allocator engine and their binding.
module sae_checker
  import sae_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input sae_out_t out_data_o
);

  // one operation at a time: stall right after an accepted beat
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepted beat");

  // with an empty result register the commit follows the capture
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_valid_o) |=> ##1 out_valid_o)
    else $error("result beat missing after accepted operation");

  // a failed operation hands out no block and nothing to clear or copy
  a_fail_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != ST_OK)) |->
      (out_data_o.result_address == '0 && out_data_o.zero_bytes == '0 &&
       out_data_o.copy_bytes == '0))
    else $error("failed operation reports an address or byte counts");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result beat changed");

endmodule

bind stack_allocator_engine sae_checker u_sae_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
